// ===== hdl/rrt_tree_extend_engine_core_defines.svh =====
// assertion macros shared by the engine
`ifndef RRT_TREE_EXTEND_ENGINE_CORE_DEFINES_SVH
`define RRT_TREE_EXTEND_ENGINE_CORE_DEFINES_SVH

// same-cycle implication
`define RRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RRT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/rrt_pkg.sv =====
package rrt_pkg;

	localparam int unsigned MAX_NODES_DEF = 1024;
	localparam int unsigned COORD_W       = 16;
	localparam int unsigned FRAC_BITS     = 4;
	localparam int unsigned STEP_W        = 15;
	localparam int unsigned IDX_W         = 10;
	localparam int unsigned CNT_W         = 11;
	localparam int unsigned CFG_IDX_W     = 3;
	localparam int unsigned CFG_DATA_W    = 16;

	// squared distance, root and divider widths
	localparam int unsigned D2_W      = 2 * COORD_W + 1;
	localparam int unsigned SQ_IN_W   = D2_W + 1;
	localparam int unsigned SQ_ROOT_W = SQ_IN_W / 2;
	localparam int unsigned NUM_W     = 2 * COORD_W + 1;
	localparam int unsigned DEN_W     = SQ_ROOT_W + 1;

	// register reset values
	localparam logic [STEP_W-1:0]         STEP_RST  = STEP_W'(10 << FRAC_BITS);
	localparam logic signed [COORD_W-1:0] OBS_XMIN_RST = '0;
	localparam logic signed [COORD_W-1:0] OBS_XMAX_RST = COORD_W'(150 << FRAC_BITS);
	localparam logic signed [COORD_W-1:0] OBS_YMIN_RST = COORD_W'(-(60 << FRAC_BITS));
	localparam logic signed [COORD_W-1:0] OBS_YMAX_RST = COORD_W'(120 << FRAC_BITS);

	typedef enum logic [1:0] {
		OP_INIT    = 2'd0,
		OP_EXTEND  = 2'd1,
		OP_CONNECT = 2'd2,
		OP_READ    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_TRAPPED  = 2'd0,
		ST_ADVANCED = 2'd1,
		ST_REACHED  = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP  = 3'd0,
		REG_XMIN  = 3'd1,
		REG_XMAX  = 3'd2,
		REG_YMIN  = 3'd3,
		REG_YMAX  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]                status;
		logic [IDX_W-1:0]          node_index;
		logic signed [COORD_W-1:0] node_x;
		logic signed [COORD_W-1:0] node_y;
		logic [IDX_W-1:0]          parent_index;
		logic                      is_root;
		logic [CNT_W-1:0]          node_count;
	} result_t;

	// handshake of the iterative units
	typedef struct packed {
		logic start;
		logic done;
	} unit_ctl_t;

endpackage

// ===== hdl/rrt_ifs.sv =====
interface rrt_item_if import rrt_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [1:0]                opcode;
	logic                      tree_id;
	logic signed [COORD_W-1:0] sample_x;
	logic signed [COORD_W-1:0] sample_y;
	logic [IDX_W-1:0]          read_index;

	modport source(output valid, opcode, tree_id, sample_x, sample_y, read_index, input ready);
	modport sink(input valid, opcode, tree_id, sample_x, sample_y, read_index, output ready);
endinterface

interface rrt_result_if import rrt_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [1:0]                status;
	logic [IDX_W-1:0]          node_index;
	logic signed [COORD_W-1:0] node_x;
	logic signed [COORD_W-1:0] node_y;
	logic [IDX_W-1:0]          parent_index;
	logic                      is_root;
	logic [CNT_W-1:0]          node_count;

	modport source(output valid, status, node_index, node_x, node_y, parent_index, is_root,
		node_count, input ready);
	modport sink(input valid, status, node_index, node_x, node_y, parent_index, is_root,
		node_count, output ready);
endinterface

interface rrt_cfg_if import rrt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/rrt_node_mem.sv =====
module rrt_node_mem import rrt_pkg::*; #(
	parameter int unsigned ADDR_W = 11,
	parameter int unsigned DATA_W = 42
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/rrt_sqrt.sv =====
module rrt_sqrt import rrt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [SQ_IN_W-1:0]   value,
	output logic                 done,
	output logic [SQ_ROOT_W-1:0] root
);

	localparam int unsigned REM_W = SQ_ROOT_W + 2;
	localparam int unsigned CNT_B = $clog2(SQ_ROOT_W + 1);

	logic [SQ_IN_W-1:0]   rad_q;
	logic [REM_W-1:0]     rem_q;
	logic [SQ_ROOT_W-1:0] root_q;
	logic [CNT_B-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [REM_W+1:0]     rem_sh;
	logic [REM_W+1:0]     trial;
	logic                 ge;

	// one result bit per cycle, two radicand bits brought down
	assign rem_sh = {rem_q, rad_q[SQ_IN_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_B'(SQ_ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_B'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SQ_IN_W-3:0], 2'b00};
			rem_q  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
			root_q <= {root_q[SQ_ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== hdl/rrt_div.sv =====
module rrt_div import rrt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num_x,
	input  logic [NUM_W-1:0] num_y,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo_x,
	output logic [NUM_W-1:0] quo_y
);

	localparam int unsigned REM_W = DEN_W + 1;
	localparam int unsigned CNT_B = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] q_q   [2];
	logic [REM_W-1:0] rem_q [2];
	logic [REM_W-1:0] rem_sh[2];
	logic             ge    [2];
	logic [DEN_W-1:0] den_q;
	logic [CNT_B-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	// two restoring lanes sharing one divisor, one quotient bit per cycle
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			rem_sh[k] = {rem_q[k][REM_W-2:0], q_q[k][NUM_W-1]};
			ge[k]     = rem_sh[k] >= {1'b0, den_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_B'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_B'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q[0]   <= num_x;
			q_q[1]   <= num_y;
			rem_q[0] <= '0;
			rem_q[1] <= '0;
			den_q    <= den;
		end else if (busy_q) begin
			for (int k = 0; k < 2; k++) begin
				rem_q[k] <= ge[k] ? REM_W'(rem_sh[k] - {1'b0, den_q}) : rem_sh[k];
				q_q[k]   <= {q_q[k][NUM_W-2:0], ge[k]};
			end
		end
	end

	assign done  = done_q;
	assign quo_x = q_q[0];
	assign quo_y = q_q[1];

endmodule

// ===== hdl/rrt_tree_extend_engine_core.sv =====
// Two-tree RRT extend engine. Items are taken one at a time: init writes the root and
// read returns one node after a single memory read; extend streams the tree's n nodes
// through the node memory's one read port to find the nearest, then, when the sample lies
// beyond step_size, runs an iterative square root and an iterative divider; connect repeats
// that per node it adds. A finished result sits in an output register, so the next item is
// taken while it waits. The node memory has no reset and needs no clearing pass.
`include "rrt_tree_extend_engine_core_defines.svh"

module rrt_tree_extend_engine_core import rrt_pkg::*; #(
	parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	rrt_item_if.sink     item,
	rrt_result_if.source result,
	rrt_cfg_if.sink      cfg
);

	localparam int unsigned AW     = $clog2(MAX_NODES);
	localparam int unsigned CW     = $clog2(MAX_NODES + 1);
	localparam int unsigned MEM_AW = AW + 1;
	localparam int unsigned MEM_DW = AW + 2 * COORD_W;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_INIT  = 11'b000_0000_0010,
		S_READ  = 11'b000_0000_0100,
		S_RDATA = 11'b000_0000_1000,
		S_EXT   = 11'b000_0001_0000,
		S_SCAN  = 11'b000_0010_0000,
		S_STEP  = 11'b000_0100_0000,
		S_SQRT  = 11'b000_1000_0000,
		S_MUL   = 11'b001_0000_0000,
		S_DIV   = 11'b010_0000_0000,
		S_CHECK = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	logic   done_pend_q;   // a built result waits to enter the output register

	// configuration registers
	logic [STEP_W-1:0]         step_q;
	logic signed [COORD_W-1:0] xmin_q, xmax_q, ymin_q, ymax_q;

	// item captured at accept
	logic [1:0]                op_q;
	logic                      t_q;
	logic signed [COORD_W-1:0] sx_q, sy_q;
	logic [IDX_W-1:0]          ridx_q;

	logic [CW-1:0] size_q [2];
	logic [CW-1:0] n;

	result_t res_q;
	result_t out_q;
	logic    out_valid_q;

	// node memory
	logic              mem_we, mem_re;
	logic [MEM_AW-1:0] mem_waddr, mem_raddr;
	logic [MEM_DW-1:0] mem_wdata, mem_rdata;
	logic signed [COORD_W-1:0] rd_x, rd_y;
	logic [AW-1:0]             rd_parent;

	// scan pipeline
	logic [CW-1:0]             rd_i_q;
	logic                      scan_issue;
	logic                      v_s1, v_s2, v_s3;
	logic [AW-1:0]             idx_s1, idx_s2, idx_s3;
	logic signed [COORD_W-1:0] x_s2, y_s2, x_s3, y_s3;
	logic [COORD_W-1:0]        adx_s2, ady_s2;
	logic [2*COORD_W-1:0]      sqx_s3, sqy_s3;
	logic [D2_W-1:0]           d2_s3;
	logic signed [COORD_W:0]   difx, dify;

	// nearest node so far
	logic [D2_W-1:0]           bestd_q;
	logic [AW-1:0]             best_idx_q;
	logic signed [COORD_W-1:0] bx_q, by_q;

	// step toward the sample
	logic [2*STEP_W-1:0]       step_sq;
	logic signed [COORD_W:0]   dlx, dly;
	logic [COORD_W-1:0]        magx_q, magy_q;
	logic                      negx_q, negy_q;
	logic [SQ_ROOT_W-1:0]      dist_q;
	logic [NUM_W-1:0]          numx_q, numy_q;
	logic signed [COORD_W-1:0] nx_q, ny_q;
	logic signed [COORD_W:0]   offx, offy;
	logic                      hit;

	unit_ctl_t            sq_ctl, dv_ctl;
	logic [SQ_ROOT_W-1:0] sq_root;
	logic [NUM_W-1:0]     quo_x, quo_y;

	logic item_acc;
	logic out_load;

	// check terms
	logic size_ok;
	logic scan_ok;
	logic out_empty;

	assign n        = size_q[t_q];
	assign item_acc = item.valid && item.ready;
	assign item.ready = (state_q == S_IDLE) && !done_pend_q;
	assign cfg.ready  = 1'b1;

	assign out_load = done_pend_q && (!out_valid_q || result.ready);

	// ---------------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RST;
			xmin_q <= OBS_XMIN_RST;
			xmax_q <= OBS_XMAX_RST;
			ymin_q <= OBS_YMIN_RST;
			ymax_q <= OBS_YMAX_RST;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_STEP: step_q <= cfg.data[STEP_W-1:0];
				REG_XMIN: xmin_q <= cfg.data;
				REG_XMAX: xmax_q <= cfg.data;
				REG_YMIN: ymin_q <= cfg.data;
				REG_YMAX: ymax_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- node memory
	// word layout: parent above y above x
	assign rd_x      = mem_rdata[COORD_W-1:0];
	assign rd_y      = mem_rdata[2*COORD_W-1:COORD_W];
	assign rd_parent = mem_rdata[MEM_DW-1:2*COORD_W];

	assign scan_issue = (state_q == S_SCAN) && (rd_i_q < n);
	assign mem_re     = scan_issue || (state_q == S_READ);
	assign mem_raddr  = (state_q == S_READ) ? {t_q, AW'(ridx_q)} : {t_q, rd_i_q[AW-1:0]};

	// writes come from init (root) or a successful extend (node at index n)
	assign mem_we    = (state_q == S_INIT) || ((state_q == S_CHECK) && !hit);
	assign mem_waddr = (state_q == S_INIT) ? {t_q, AW'(0)} : {t_q, n[AW-1:0]};
	assign mem_wdata = (state_q == S_INIT) ? {AW'(0), sy_q, sx_q} : {best_idx_q, ny_q, nx_q};

	rrt_node_mem #(
		.ADDR_W (MEM_AW),
		.DATA_W (MEM_DW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// ---------------------------------------------------------------- nearest-node scan
	// s1: memory read, s2: absolute deltas, s3: squares, then sum and compare
	assign difx  = {sx_q[COORD_W-1], sx_q} - {rd_x[COORD_W-1], rd_x};
	assign dify  = {sy_q[COORD_W-1], sy_q} - {rd_y[COORD_W-1], rd_y};
	assign d2_s3 = D2_W'(sqx_s3) + D2_W'(sqy_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= scan_issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_i_q[AW-1:0];
		idx_s2 <= idx_s1;
		x_s2   <= rd_x;
		y_s2   <= rd_y;
		adx_s2 <= difx[COORD_W] ? COORD_W'(-difx) : COORD_W'(difx);
		ady_s2 <= dify[COORD_W] ? COORD_W'(-dify) : COORD_W'(dify);
		idx_s3 <= idx_s2;
		x_s3   <= x_s2;
		y_s3   <= y_s2;
		sqx_s3 <= adx_s2 * adx_s2;
		sqy_s3 <= ady_s2 * ady_s2;
		// first minimum wins: strict compare, node 0 always seeds
		if (v_s3 && ((idx_s3 == '0) || (d2_s3 < bestd_q))) begin
			bestd_q    <= d2_s3;
			best_idx_q <= idx_s3;
			bx_q       <= x_s3;
			by_q       <= y_s3;
		end
	end

	// ---------------------------------------------------------------- step arithmetic
	assign step_sq = step_q * step_q;
	assign dlx     = {sx_q[COORD_W-1], sx_q} - {bx_q[COORD_W-1], bx_q};
	assign dly     = {sy_q[COORD_W-1], sy_q} - {by_q[COORD_W-1], by_q};
	assign offx    = negx_q ? -(COORD_W+1)'(quo_x[COORD_W-1:0]) : (COORD_W+1)'(quo_x[COORD_W-1:0]);
	assign offy    = negy_q ? -(COORD_W+1)'(quo_y[COORD_W-1:0]) : (COORD_W+1)'(quo_y[COORD_W-1:0]);

	// obstacle rectangle, bounds inclusive
	assign hit = (nx_q >= xmin_q) && (nx_q <= xmax_q) && (ny_q >= ymin_q) && (ny_q <= ymax_q);

	assign sq_ctl.start = (state_q == S_STEP) && ({3'b000, step_sq} < bestd_q);
	assign dv_ctl.start = (state_q == S_MUL);

	rrt_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_ctl.start),
		.value  (SQ_IN_W'(bestd_q)),
		.done   (sq_ctl.done),
		.root   (sq_root)
	);

	// round half away: (2*step*|d| + dist) / (2*dist)
	rrt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_ctl.start),
		.num_x  (numx_q),
		.num_y  (numy_q),
		.den    ({dist_q, 1'b0}),
		.done   (dv_ctl.done),
		.quo_x  (quo_x),
		.quo_y  (quo_y)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_STEP) begin
			magx_q <= dlx[COORD_W] ? COORD_W'(-dlx) : COORD_W'(dlx);
			magy_q <= dly[COORD_W] ? COORD_W'(-dly) : COORD_W'(dly);
			negx_q <= dlx[COORD_W];
			negy_q <= dly[COORD_W];
			// within one step the sample itself is taken
			nx_q   <= sx_q;
			ny_q   <= sy_q;
		end
		// numerators ready before the divider starts in S_MUL
		if (sq_ctl.done) begin
			dist_q <= sq_root;
			numx_q <= NUM_W'({step_q, 1'b0} * magx_q) + NUM_W'(sq_root);
			numy_q <= NUM_W'({step_q, 1'b0} * magy_q) + NUM_W'(sq_root);
		end
		if (dv_ctl.done) begin
			nx_q <= COORD_W'({bx_q[COORD_W-1], bx_q} + offx);
			ny_q <= COORD_W'({by_q[COORD_W-1], by_q} + offy);
		end
	end

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			done_pend_q <= 1'b0;
			size_q[0]   <= '0;
			size_q[1]   <= '0;
			rd_i_q      <= '0;
		end else begin
			if (out_load) begin
				done_pend_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						case (op_t'(item.opcode))
							OP_INIT:  state_q <= S_INIT;
							OP_READ:  state_q <= S_READ;
							default:  state_q <= S_EXT;
						endcase
					end
				end
				S_INIT: begin
					size_q[t_q] <= CW'(1);
					done_pend_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_READ: begin
					state_q <= S_RDATA;
				end
				S_RDATA: begin
					done_pend_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_EXT: begin
					rd_i_q <= '0;
					if ((n == '0) || (n >= CW'(MAX_NODES))) begin
						done_pend_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_issue) begin
						rd_i_q <= rd_i_q + 1'b1;
					end else if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					state_q <= sq_ctl.start ? S_SQRT : S_CHECK;
				end
				S_SQRT: begin
					if (sq_ctl.done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (dv_ctl.done) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (!hit) begin
						size_q[t_q] <= n + 1'b1;
					end
					// connect keeps extending while it only advances
					if (!hit && (op_q == OP_CONNECT) && !((nx_q == sx_q) && (ny_q == sy_q))) begin
						state_q <= S_EXT;
					end else begin
						done_pend_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item capture and result build
	always_ff @(posedge clk) begin
		if (item_acc) begin
			op_q   <= item.opcode;
			t_q    <= item.tree_id;
			sx_q   <= item.sample_x;
			sy_q   <= item.sample_y;
			ridx_q <= item.read_index;
		end
		case (state_q)
			S_INIT: begin
				res_q.status       <= ST_TRAPPED;
				res_q.node_index   <= '0;
				res_q.node_x       <= sx_q;
				res_q.node_y       <= sy_q;
				res_q.parent_index <= '0;
				res_q.is_root      <= 1'b1;
				res_q.node_count   <= CNT_W'(1);
			end
			S_RDATA: begin
				res_q.status     <= ST_TRAPPED;
				res_q.node_index <= ridx_q;
				res_q.node_count <= CNT_W'(n);
				if ((CW + IDX_W)'(ridx_q) < (CW + IDX_W)'(n)) begin
					res_q.node_x       <= rd_x;
					res_q.node_y       <= rd_y;
					res_q.parent_index <= IDX_W'(rd_parent);
					res_q.is_root      <= (ridx_q == '0);
				end else begin
					res_q.node_x       <= '0;
					res_q.node_y       <= '0;
					res_q.parent_index <= '0;
					res_q.is_root      <= 1'b0;
				end
			end
			S_EXT: begin
				// empty tree answers trapped, a full one answers full
				if ((n == '0) || (n >= CW'(MAX_NODES))) begin
					res_q.status       <= (n == '0) ? ST_TRAPPED : ST_FULL;
					res_q.node_index   <= '0;
					res_q.node_x       <= '0;
					res_q.node_y       <= '0;
					res_q.parent_index <= '0;
					res_q.is_root      <= 1'b0;
					res_q.node_count   <= CNT_W'(n);
				end
			end
			S_CHECK: begin
				if (hit) begin
					res_q.status       <= ST_TRAPPED;
					res_q.node_index   <= '0;
					res_q.node_x       <= '0;
					res_q.node_y       <= '0;
					res_q.parent_index <= '0;
					res_q.is_root      <= 1'b0;
					res_q.node_count   <= CNT_W'(n);
				end else begin
					res_q.status       <= ((nx_q == sx_q) && (ny_q == sy_q)) ? ST_REACHED
						: ST_ADVANCED;
					res_q.node_index   <= IDX_W'(n);
					res_q.node_x       <= nx_q;
					res_q.node_y       <= ny_q;
					res_q.parent_index <= IDX_W'(best_idx_q);
					res_q.is_root      <= 1'b0;
					res_q.node_count   <= CNT_W'(n + 1'b1);
				end
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.status       = out_q.status;
	assign result.node_index   = out_q.node_index;
	assign result.node_x       = out_q.node_x;
	assign result.node_y       = out_q.node_y;
	assign result.parent_index = out_q.parent_index;
	assign result.is_root      = out_q.is_root;
	assign result.node_count   = out_q.node_count;

	// ---------------------------------------------------------------- checks
	assign size_ok   = (size_q[0] <= CW'(MAX_NODES)) && (size_q[1] <= CW'(MAX_NODES));
	assign scan_ok   = (rd_i_q < n) && (n < CW'(MAX_NODES));
	assign out_empty = !out_valid_q && !done_pend_q;

	`RRT_ASSERT_IMP(a_size_bound, clk, arst_n, 1'b1, size_ok, "tree size beyond capacity")
	`RRT_ASSERT_IMP(a_scan_in_tree, clk, arst_n, scan_issue, scan_ok, "scan reads past nodes")
	`RRT_ASSERT_NXT(a_out_from_pend, clk, arst_n, out_empty, !out_valid_q, "unbuilt result shown")
	`RRT_ASSERT_IMP(a_state_onehot, clk, arst_n, 1'b1, $onehot(state_q), "state not one-hot")

endmodule
